>>> design/byte_parallel_trinomial_lfsr_assert.svh
// assertion macros shared by the checker
`ifndef BYTE_PARALLEL_TRINOMIAL_LFSR_ASSERT_SVH
`define BYTE_PARALLEL_TRINOMIAL_LFSR_ASSERT_SVH

// same-cycle implication, muted during reset
`define BTL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btl check failed");

// next-cycle implication, muted during reset
`define BTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btl check failed");

// next-cycle implication that also covers reset
`define BTL_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("btl check failed");

`endif

>>> design/btl_pkg.sv
package btl_pkg;

  localparam int SEED_MAX_DEF = 256;
  localparam int POOL_DEPTH   = 256;
  // w + 83 seen from the old write position: (wp - 1) + 83
  localparam logic [7:0] POOL_TAP = 8'd82;

  localparam logic [1:0] REQ_SEED  = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_STOMP = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_FIX,
    ST_GET_A,
    ST_GET_B,
    ST_GET_C,
    ST_GET_D,
    ST_STOMP_RD,
    ST_STOMP_WR
  } state_t;

  typedef enum logic {
    BU_XOR,
    BU_FOLD
  } bu_op_t;

  typedef struct packed {
    bu_op_t      op;
    logic [15:0] acc;
    logic [7:0]  operand;
  } bu_req_t;

  typedef struct packed {
    logic [15:0] sum;
    logic [7:0]  val;
  } bu_res_t;

endpackage

>>> design/btl_ram.sv
module btl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/btl_byte_unit.sv
module btl_byte_unit (
  input  btl_pkg::bu_req_t req,
  output btl_pkg::bu_res_t res
);
  import btl_pkg::*;

  always_comb begin
    res.sum = req.acc + 16'(req.operand);
    case (req.op)
      BU_FOLD: res.val = res.sum[7:0] + res.sum[15:8];
      BU_XOR:  res.val = req.acc[7:0] ^ req.operand;
      default: res.val = req.acc[7:0] ^ req.operand;
    endcase
  end

endmodule

>>> design/btl_seq.sv
module btl_seq #(
  parameter int SEED_MAX = btl_pkg::SEED_MAX_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [1:0]                                         in_req,
  input  logic [7:0]                                         in_byte,
  input  logic                                               in_last,
  input  logic                                               check_enable,
  input  logic                                               out_free,
  output logic                                               out_load,
  output logic [7:0]                                         out_byte,
  output logic                                               pool_we,
  output logic [7:0]                                         pool_waddr,
  output logic [7:0]                                         pool_wdata,
  output logic                                               pool_re,
  output logic [7:0]                                         pool_raddr,
  input  logic [7:0]                                         pool_rdata,
  output logic                                               seed_we,
  output logic [((SEED_MAX > 1) ? $clog2(SEED_MAX) : 1)-1:0] seed_waddr,
  output logic [7:0]                                         seed_wdata,
  output logic                                               seed_re,
  output logic [((SEED_MAX > 1) ? $clog2(SEED_MAX) : 1)-1:0] seed_raddr,
  input  logic [7:0]                                         seed_rdata
);
  import btl_pkg::*;

  localparam int SAW = (SEED_MAX > 1) ? $clog2(SEED_MAX) : 1;
  localparam int SCW = $clog2(SEED_MAX + 1);

  state_t          state, state_next;
  logic [8:0]      cnt, cnt_next;
  logic [7:0]      wp, wp_next;
  logic [SCW-1:0]  seed_count, seed_count_next;
  logic [SCW-1:0]  seed_len, seed_len_next;
  logic [SAW-1:0]  rd_k, rd_k_next;
  logic [15:0]     sum, sum_next;
  logic [7:0]      acc, acc_next;
  logic [7:0]      e0, e0_next;
  logic [7:0]      any_one, any_one_next;
  logic [7:0]      all_one, all_one_next;

  logic            take;
  logic            seed_full;
  logic [SCW-1:0]  count_after;
  logic [SCW-1:0]  k_inc;
  logic [7:0]      wm1;
  bu_req_t         bu_req;
  bu_res_t         bu_res;

  btl_byte_unit u_unit (
    .req (bu_req),
    .res (bu_res)
  );

  assign take        = in_valid && in_ready;
  assign seed_full   = (seed_count == SCW'(SEED_MAX));
  assign count_after = seed_full ? seed_count : seed_count + 1'b1;
  assign k_inc       = SCW'(rd_k) + 1'b1;
  assign wm1         = wp - 8'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt[7:0] == 8'hFF) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          case (in_req)
            REQ_SEED:  if (in_last) state_next = ST_FILL;
            REQ_GET:   state_next = ST_GET_A;
            REQ_STOMP: state_next = ST_STOMP_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (cnt == 9'd256) state_next = ST_FIX;
      end
      ST_FIX:      state_next = ST_IDLE;
      ST_GET_A:    state_next = ST_GET_B;
      ST_GET_B:    state_next = ST_GET_C;
      ST_GET_C:    state_next = ST_GET_D;
      ST_GET_D: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_STOMP_RD: state_next = ST_STOMP_WR;
      ST_STOMP_WR: begin
        if (cnt[7:0] == 8'd254) state_next = ST_IDLE;
        else                    state_next = ST_STOMP_RD;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs: memory ports, shared unit operands, handshake
  always_comb begin
    in_ready       = (state == ST_IDLE);
    out_load       = 1'b0;
    out_byte       = bu_res.val;
    pool_we        = 1'b0;
    pool_waddr     = cnt[7:0];
    pool_wdata     = bu_res.val;
    pool_re        = 1'b0;
    pool_raddr     = cnt[7:0];
    seed_we        = 1'b0;
    seed_waddr     = seed_count[SAW-1:0];
    seed_wdata     = in_byte;
    seed_re        = 1'b0;
    seed_raddr     = rd_k;
    bu_req.op      = BU_XOR;
    bu_req.acc     = {8'h00, acc};
    bu_req.operand = pool_rdata;
    case (state)
      ST_CLEAR: begin
        pool_we    = 1'b1;
        pool_wdata = 8'h00;
      end
      ST_IDLE: begin
        seed_we = take && (in_req == REQ_SEED) && !seed_full;
      end
      ST_FILL: begin
        seed_re        = !cnt[8];
        bu_req.op      = BU_FOLD;
        bu_req.acc     = sum;
        bu_req.operand = seed_rdata;
        pool_we        = (cnt != 9'd0);
        pool_waddr     = cnt[7:0] - 8'd1;
      end
      ST_FIX: begin
        bu_req.acc     = {8'h00, e0};
        bu_req.operand = check_enable ? (all_one | ~any_one) : 8'h00;
        pool_we        = 1'b1;
        pool_waddr     = 8'd0;
      end
      ST_GET_A: begin
        pool_re    = 1'b1;
        pool_raddr = wp;
      end
      ST_GET_B: begin
        pool_re    = 1'b1;
        pool_raddr = wp + POOL_TAP;
        bu_req.acc = 16'h0000;
      end
      ST_GET_C: begin
        pool_re    = 1'b1;
        pool_raddr = wm1;
      end
      ST_GET_D: begin
        out_load   = out_free;
        pool_we    = out_free;
        pool_waddr = wm1;
      end
      ST_STOMP_RD: begin
        pool_re = 1'b1;
      end
      ST_STOMP_WR: begin
        bu_req.acc     = {8'h00, pool_rdata};
        bu_req.operand = ~cnt[7:0];
        pool_we        = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath and counter updates
  always_comb begin
    cnt_next        = cnt;
    wp_next         = wp;
    seed_count_next = seed_count;
    seed_len_next   = seed_len;
    rd_k_next       = rd_k;
    sum_next        = sum;
    acc_next        = acc;
    e0_next         = e0;
    any_one_next    = any_one;
    all_one_next    = all_one;
    case (state)
      ST_CLEAR: cnt_next = cnt + 9'd1;
      ST_IDLE: begin
        cnt_next = 9'd0;
        if (take && (in_req == REQ_SEED)) begin
          if (in_last) begin
            seed_len_next   = count_after;
            seed_count_next = '0;
            sum_next        = 16'(count_after);
            rd_k_next       = '0;
          end else begin
            seed_count_next = count_after;
          end
        end
      end
      ST_FILL: begin
        cnt_next  = cnt + 9'd1;
        rd_k_next = (k_inc >= seed_len) ? '0 : k_inc[SAW-1:0];
        if (cnt != 9'd0) begin
          sum_next = bu_res.sum;
          if (cnt == 9'd1) begin
            e0_next      = bu_res.val;
            any_one_next = bu_res.val;
            all_one_next = bu_res.val;
          end else begin
            any_one_next = any_one | bu_res.val;
            all_one_next = all_one & bu_res.val;
          end
        end
      end
      ST_FIX: wp_next = 8'd0;
      ST_GET_B: acc_next = bu_res.val;
      ST_GET_C: acc_next = bu_res.val;
      ST_GET_D: begin
        if (out_free) wp_next = wm1;
      end
      ST_STOMP_WR: cnt_next = cnt + 9'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= 9'd0;
      wp         <= 8'd0;
      seed_count <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      wp         <= wp_next;
      seed_count <= seed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    seed_len <= seed_len_next;
    rd_k     <= rd_k_next;
    sum      <= sum_next;
    acc      <= acc_next;
    e0       <= e0_next;
    any_one  <= any_one_next;
    all_one  <= all_one_next;
  end

endmodule

>>> design/byte_parallel_trinomial_lfsr.sv
// get: taps read in GET_A to GET_C; GET_D waits for a free output, no new request till idle
// seed byte: stored; last seed byte: pool refill (one pool entry a cycle, then lane check)
// stomp: pool entries 0 to 254 each read in ST_STOMP_RD, then written in ST_STOMP_WR
// reset (synchronous): clears control state, then the pool in ST_CLEAR with tready low
// check_enable resets to 0; the user writes it only while idle, not enforced by the block
module byte_parallel_trinomial_lfsr #(
  parameter int SEED_MAX = btl_pkg::SEED_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] seed_byte
  input  logic       s_axis_tlast,   // seed_last
  input  logic [1:0] s_axis_tuser,   // [1:0] req_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] random_byte
);
  import btl_pkg::*;

  localparam int SAW = (SEED_MAX > 1) ? $clog2(SEED_MAX) : 1;

  logic           check_enable;
  logic           out_free;
  logic           out_load;
  logic [7:0]     out_byte;
  logic           pool_we;
  logic [7:0]     pool_waddr;
  logic [7:0]     pool_wdata;
  logic           pool_re;
  logic [7:0]     pool_raddr;
  logic [7:0]     pool_rdata;
  logic           seed_we;
  logic [SAW-1:0] seed_waddr;
  logic [7:0]     seed_wdata;
  logic           seed_re;
  logic [SAW-1:0] seed_raddr;
  logic [7:0]     seed_rdata;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  btl_seq #(
    .SEED_MAX (SEED_MAX)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_req       (s_axis_tuser),
    .in_byte      (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .check_enable (check_enable),
    .out_free     (out_free),
    .out_load     (out_load),
    .out_byte     (out_byte),
    .pool_we      (pool_we),
    .pool_waddr   (pool_waddr),
    .pool_wdata   (pool_wdata),
    .pool_re      (pool_re),
    .pool_raddr   (pool_raddr),
    .pool_rdata   (pool_rdata),
    .seed_we      (seed_we),
    .seed_waddr   (seed_waddr),
    .seed_wdata   (seed_wdata),
    .seed_re      (seed_re),
    .seed_raddr   (seed_raddr),
    .seed_rdata   (seed_rdata)
  );

  btl_ram #(
    .WIDTH (8),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .re    (pool_re),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  btl_ram #(
    .WIDTH (8),
    .DEPTH (SEED_MAX)
  ) u_seed (
    .clk   (clk),
    .we    (seed_we),
    .waddr (seed_waddr),
    .wdata (seed_wdata),
    .re    (seed_re),
    .raddr (seed_raddr),
    .rdata (seed_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) check_enable <= cfg_wdata;
      if (out_load)           m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= out_byte;
  end

endmodule

>>> design/btl_checker.sv
module btl_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import btl_pkg::*;

`include "byte_parallel_trinomial_lfsr_assert.svh"

  // a waiting result beat holds
  `BTL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // the pool is cleared after reset before anything is taken or given
  `BTL_ASSERT_NEXT_ALWAYS(a_reset_quiet, rst, !s_axis_tready && !m_axis_tvalid)

  // a get keeps the block busy while it works
  `BTL_ASSERT_NEXT(a_get_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_GET), !s_axis_tready)

  // no result appears in the cycle after any request beat
  `BTL_ASSERT_NEXT(a_no_instant, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

  // a result only appears while the block is busy
  `BTL_ASSERT_NOW(a_rise_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind byte_parallel_trinomial_lfsr btl_checker u_btl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/tb_byte_parallel_trinomial_lfsr.sv
module tb_byte_parallel_trinomial_lfsr;
  import btl_pkg::*;

  localparam int SEED_DEPTH = SEED_MAX_DEF;
  localparam logic [1:0] REQ_NONE = 2'd3;
  // quiet cycles allowed after the last result, covers a stomp pass
  localparam int SETTLE_CYCLES = 600;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 4;
  localparam int PHASE_ITEMS = 245;
  localparam int DIR_ROWS = 22;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
    logic       last;
    logic       fixed;
    logic [7:0] fixed_val;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] seed_byte
  logic       s_axis_tlast = 1'b0;   // seed_last
  logic [1:0] s_axis_tuser = 2'd0;   // [1:0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] random_byte

  // shadow of the generator
  logic [7:0] pool_img [POOL_DEPTH];
  logic [7:0] seed_img [SEED_DEPTH];
  logic [7:0] wr_pos;
  int unsigned seed_len;
  bit check_en;

  logic [7:0] random_bytes_due [$];
  int errors = 0;
  int items_sent = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int quiet = 0;

  localparam bit PHASE_CHECK [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};
  localparam bit PHASE_LONG [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0};

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_GET,   8'h00, 1'b0, 1'b1, 8'h00},  // get on the cleared pool
    '{REQ_GET,   8'hFF, 1'b1, 1'b1, 8'h00},
    '{REQ_NONE,  8'hFF, 1'b1, 1'b0, 8'h00},  // unknown request, dropped
    '{REQ_STOMP, 8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_GET,   8'h5A, 1'b0, 1'b0, 8'h00},
    '{REQ_GET,   8'hA5, 1'b1, 1'b0, 8'h00},
    '{REQ_SEED,  8'h00, 1'b1, 1'b0, 8'h00},  // one zero byte gives a flat pool
    '{REQ_GET,   8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_GET,   8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_SEED,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{REQ_SEED,  8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_SEED,  8'h80, 1'b0, 1'b0, 8'h00},
    '{REQ_SEED,  8'h01, 1'b1, 1'b0, 8'h00},
    '{REQ_GET,   8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_STOMP, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{REQ_GET,   8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_GET,   8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_SEED,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{REQ_GET,   8'h00, 1'b1, 1'b0, 8'h00},  // get in the middle of a seed
    '{REQ_NONE,  8'h00, 1'b0, 1'b0, 8'h00},
    '{REQ_SEED,  8'h7F, 1'b1, 1'b0, 8'h00},
    '{REQ_GET,   8'h00, 1'b0, 1'b0, 8'h00}
  };

  byte_parallel_trinomial_lfsr u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void refill_pool();
    int unsigned sum;
    int unsigned k;
    logic [7:0] any_one;
    logic [7:0] all_one;
    sum = seed_len;
    k = 0;
    any_one = 8'h00;
    all_one = 8'hFF;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      sum += seed_img[k];
      k++;
      if (k >= seed_len) k = 0;
      pool_img[i] = 8'(sum + (sum >> 8));
      any_one |= pool_img[i];
      all_one &= pool_img[i];
    end
    // lane repair: flat lanes get flipped in entry zero
    if (check_en) pool_img[0] ^= all_one | ~any_one;
    wr_pos = 8'd0;
    seed_len = 0;
  endfunction

  function automatic void advance_pool(input logic [1:0] req, input logic [7:0] b,
                                       input logic last, output bit has_byte,
                                       output logic [7:0] out_byte);
    logic [7:0] w;
    has_byte = 1'b0;
    out_byte = 8'h00;
    case (req)
      REQ_SEED: begin
        if (seed_len < SEED_DEPTH) begin
          seed_img[seed_len] = b;
          seed_len++;
        end
        if (last && seed_len > 0) refill_pool();
      end
      REQ_GET: begin
        w = wr_pos - 8'd1;
        pool_img[w] ^= pool_img[8'(w + 8'd1)] ^ pool_img[8'(w + 8'd83)];
        wr_pos = w;
        has_byte = 1'b1;
        out_byte = pool_img[w];
      end
      REQ_STOMP: begin
        for (int k = 0; k < 255; k++) pool_img[k] ^= 8'(255 - k);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [7:0] b, input logic last,
                              input bit fixed, input logic [7:0] fixed_val);
    int gap;
    bit has_byte;
    logic [7:0] rb;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      if ($urandom_range(0, 31) == 0) tx_calm = $urandom_range(20, 80);
      gap = pick_gap();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_pool(req, b, last, has_byte, rb);
    if (has_byte) random_bytes_due.push_back(fixed ? fixed_val : rb);
    if (req != REQ_NONE) items_sent++;
  endtask

  task automatic send_other(input logic [1:0] req);
    send_request(req, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
  endtask

  task automatic send_seed(input int len, input bit close, input bit noisy);
    int r;
    for (int j = 0; j < len; j++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 2);
        send_other(r == 0 ? REQ_GET : (r == 1 ? REQ_STOMP : REQ_NONE));
      end
      send_request(REQ_SEED, 8'($urandom), close && (j == len - 1), 1'b0, 8'h00);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (random_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_check_enable(input bit v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    check_en = v;
  endtask

  task automatic run_random_phase(input int budget, input bit long_seed);
    int stop_at;
    int r;
    stop_at = items_sent + budget;
    // flat pool first so the lane repair is exercised under this setting
    send_request(REQ_SEED, 8'h00, 1'b1, 1'b0, 8'h00);
    repeat (3) send_other(REQ_GET);
    // overflowing seed, last byte arrives with the store full
    if (long_seed) send_seed($urandom_range(257, 290), 1'b1, 1'b0);
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_seed($urandom_range(1, 12), $urandom_range(0, 7) != 0, 1'b1);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 12)) send_other(REQ_GET);
      end else if (r < 90) begin
        send_other(REQ_STOMP);
      end else if (r < 95) begin
        send_other(REQ_NONE);
      end else begin
        send_request(REQ_SEED, $urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b1, 1'b0, 8'h00);
      end
    end
  endtask

  // result side: random back-pressure with calm stretches
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (m_axis_tready) begin
      if ($urandom_range(0, 31) == 0) begin
        rx_hold <= $urandom_range(30, 150);
      end else begin
        rx_hold <= pick_gap();
        m_axis_tready <= 1'b0;
      end
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (random_bytes_due.size() == 0) begin
        $error("random_byte: unexpected beat, actual %0h", m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== random_bytes_due[0]) begin
          $error("random_byte: expected %0h, actual %0h", random_bytes_due[0], m_axis_tdata);
          errors++;
        end
        void'(random_bytes_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("byte_parallel_trinomial_lfsr verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_DEPTH; i++) pool_img[i] = 8'h00;
    wr_pos = 8'd0;
    seed_len = 0;
    check_en = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_check_enable(1'b0);
    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_rows[i].req, dir_rows[i].data, dir_rows[i].last,
                   dir_rows[i].fixed, dir_rows[i].fixed_val);
    drain();
    for (int p = 0; p < PHASES; p++) begin
      write_check_enable(PHASE_CHECK[p]);
      run_random_phase(PHASE_ITEMS, PHASE_LONG[p]);
      drain();
    end
    if (errors == 0) begin
      $display("byte_parallel_trinomial_lfsr verification clean");
    end else begin
      $display("byte_parallel_trinomial_lfsr verification failed");
    end
    $finish;
  end

endmodule

>>> byte_parallel_trinomial_lfsr.f
+incdir+design
design/btl_pkg.sv
design/btl_ram.sv
design/btl_byte_unit.sv
design/btl_seq.sv
design/byte_parallel_trinomial_lfsr.sv
design/btl_checker.sv
tb/sv/tb_byte_parallel_trinomial_lfsr.sv
